FILE: sv/grid_maze_dfs_solver_top_assert.svh
// Concurrent assertion helpers; the using scope provides clk and rst_n.
`ifndef GRID_MAZE_DFS_SOLVER_TOP_ASSERT_SVH
`define GRID_MAZE_DFS_SOLVER_TOP_ASSERT_SVH

`define GMDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define GMDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`define GMDS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

FILE: sv/gmds_pkg.sv
`default_nettype none
package gmds_pkg;

  localparam int CW              = 5;
  localparam int ROW_BITS_W      = 32;
  localparam int PATH_W          = 10;
  localparam int MOVE_W          = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int GRID_SIDE_DEF   = 32;
  localparam int STACK_DEPTH_DEF = 512;

  localparam logic [MOVE_W-1:0] MOVE_MAX = '1;

  localparam logic [CW-1:0] RST_START_ROW = CW'(1);
  localparam logic [CW-1:0] RST_START_COL = CW'(1);
  localparam logic [CW-1:0] RST_EXIT_ROW  = CW'(20);
  localparam logic [CW-1:0] RST_EXIT_COL  = CW'(11);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_ROW,
    CFG_START_COL,
    CFG_EXIT_ROW,
    CFG_EXIT_COL
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_INIT,
    S_FETCH,
    S_STEP,
    S_POP,
    S_FIN
  } walk_state_t;

  typedef struct packed {
    logic                  valid;
    logic [CW-1:0]         row_index;
    logic [ROW_BITS_W-1:0] row_bits;
    logic                  last_row;
  } load_t;

  typedef struct packed {
    logic [CW-1:0] start_row;
    logic [CW-1:0] start_col;
    logic [CW-1:0] exit_row;
    logic [CW-1:0] exit_col;
  } cfg_t;

  typedef struct packed {
    logic              found;
    logic [PATH_W-1:0] path_length;
    logic [MOVE_W-1:0] move_count;
    logic              stack_overflow;
  } result_t;

endpackage
`default_nettype wire

FILE: sv/gmds_ram.sv
`default_nettype none
module gmds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: sv/gmds_walker.sv
`default_nettype none
`include "grid_maze_dfs_solver_top_assert.svh"
module gmds_walker #(
  parameter int GRID_SIDE   = gmds_pkg::GRID_SIDE_DEF,
  parameter int STACK_DEPTH = gmds_pkg::STACK_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gmds_pkg::load_t   ld,
  output logic                   ld_stall,
  input  wire gmds_pkg::cfg_t    cfg,
  output logic                   res_valid,
  output gmds_pkg::result_t      res,
  input  wire logic              res_take
);

  localparam int SIDE = (GRID_SIDE < gmds_pkg::ROW_BITS_W) ? GRID_SIDE : gmds_pkg::ROW_BITS_W;
  localparam int AW   = $clog2(SIDE);
  localparam int WW   = 2 * SIDE;
  localparam int SAW  = $clog2(STACK_DEPTH);
  localparam int DW   = $clog2(STACK_DEPTH + 1);
  localparam int CW   = gmds_pkg::CW;
  localparam logic [CW:0]   SIDE_X = (CW+1)'(SIDE);
  localparam logic [AW-1:0] LAST_IX = AW'(SIDE - 1);
  localparam logic [DW-1:0] FULL_D  = DW'(STACK_DEPTH);

  gmds_pkg::walk_state_t state_r, state_nxt;

  logic [1:0]               fcnt_r, fcnt_nxt;
  logic [CW-1:0]            cur_row_r, cur_row_nxt;
  logic [CW-1:0]            cur_col_r, cur_col_nxt;
  logic [DW-1:0]            depth_r, depth_nxt;
  logic [gmds_pkg::MOVE_W-1:0] moves_r, moves_nxt;
  logic                     found_r, found_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     mark_r, mark_nxt;
  logic                     rd_ok_r, rd_ok_nxt;
  logic [SIDE-1:0]          row_valid_r, row_valid_nxt;
  logic [WW-1:0]            up_r, up_nxt;
  logic [WW-1:0]            mid_r, mid_nxt;
  logic [WW-1:0]            dn_r, dn_nxt;

  logic            g_we, g_re;
  logic [AW-1:0]   g_waddr, g_raddr;
  logic [WW-1:0]   g_wdata, g_rdata;
  logic            s_we, s_re;
  logic [SAW-1:0]  s_waddr, s_raddr;
  logic [2*CW-1:0] s_wdata, s_rdata;

  logic [AW-1:0]   ridx, cidx, up_addr, dn_addr;
  logic            at_top, at_bot, at_left, at_right;
  logic [SIDE-1:0] cand_up, cand_mid, cand_dn;
  logic            can_r, can_u, can_l, can_d, any_mv;
  logic            mv_up, mv_left, mv_down;
  logic [CW-1:0]   mv_row, mv_col;
  logic [WW-1:0]   cur_bit, mv_bit, fetched;
  logic            at_exit, stack_full, in_step;
  logic            step_mark, step_exit, step_ovf, step_push, step_stuck, step_pop;
  logic            row_in_grid, start_out;
  logic [gmds_pkg::MOVE_W-1:0] moves_inc;
  logic [DW-1:0]   pop_top;

  gmds_ram #(.WIDTH(WW), .DEPTH(SIDE)) u_grid (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .re(g_re), .raddr(g_raddr), .rdata(g_rdata)
  );

  gmds_ram #(.WIDTH(2*CW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );

  assign ridx     = cur_row_r[AW-1:0];
  assign cidx     = cur_col_r[AW-1:0];
  assign at_top   = (ridx == '0);
  assign at_bot   = (ridx == LAST_IX);
  assign at_left  = (cidx == '0);
  assign at_right = (cidx == LAST_IX);
  assign up_addr  = at_top ? ridx : ridx - 1'b1;
  assign dn_addr  = at_bot ? ridx : ridx + 1'b1;

  assign cand_up  = up_r[SIDE-1:0]  & ~up_r[WW-1:SIDE];
  assign cand_mid = mid_r[SIDE-1:0] & ~mid_r[WW-1:SIDE];
  assign cand_dn  = dn_r[SIDE-1:0]  & ~dn_r[WW-1:SIDE];

  assign can_r  = !at_right && cand_mid[cidx + 1'b1];
  assign can_u  = !at_top   && cand_up[cidx];
  assign can_l  = !at_left  && cand_mid[cidx - 1'b1];
  assign can_d  = !at_bot   && cand_dn[cidx];
  assign any_mv = can_r || can_u || can_l || can_d;

  assign mv_up   = !can_r && can_u;
  assign mv_left = !can_r && !can_u && can_l;
  assign mv_down = !can_r && !can_u && !can_l && can_d;
  assign mv_row  = mv_up ? cur_row_r - 1'b1 : (mv_down ? cur_row_r + 1'b1 : cur_row_r);
  assign mv_col  = can_r ? cur_col_r + 1'b1 : (mv_left ? cur_col_r - 1'b1 : cur_col_r);

  assign cur_bit = WW'(1) << (SIDE + int'(cidx));
  assign mv_bit  = WW'(1) << (SIDE + int'(mv_col[AW-1:0]));
  assign fetched = rd_ok_r ? g_rdata : '0;

  assign at_exit    = (cur_row_r == cfg.exit_row) && (cur_col_r == cfg.exit_col);
  assign stack_full = (depth_r == FULL_D);
  assign in_step    = (state_r == gmds_pkg::S_STEP);
  assign step_mark  = in_step && mark_r;
  assign step_exit  = in_step && !mark_r && at_exit;
  assign step_ovf   = in_step && !mark_r && !at_exit && any_mv && stack_full;
  assign step_push  = in_step && !mark_r && !at_exit && any_mv && !stack_full;
  assign step_stuck = in_step && !mark_r && !at_exit && !any_mv && (depth_r == '0);
  assign step_pop   = in_step && !mark_r && !at_exit && !any_mv && (depth_r != '0);

  assign row_in_grid = ({1'b0, ld.row_index} < SIDE_X);
  assign start_out   = ({1'b0, cfg.start_row} >= SIDE_X) || ({1'b0, cfg.start_col} >= SIDE_X);
  assign moves_inc   = (moves_r == gmds_pkg::MOVE_MAX) ? moves_r : moves_r + 1'b1;
  assign pop_top     = depth_r - DW'(2);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gmds_pkg::S_LOAD: begin
        if (ld.valid && ld.last_row) state_nxt = gmds_pkg::S_INIT;
      end
      gmds_pkg::S_INIT: begin
        state_nxt = start_out ? gmds_pkg::S_FIN : gmds_pkg::S_FETCH;
      end
      gmds_pkg::S_FETCH: begin
        if (fcnt_r == 2'd3) state_nxt = gmds_pkg::S_STEP;
      end
      gmds_pkg::S_STEP: begin
        if (step_exit || step_ovf || step_stuck) begin
          state_nxt = gmds_pkg::S_FIN;
        end else if (step_push) begin
          state_nxt = (mv_up || mv_down) ? gmds_pkg::S_FETCH : gmds_pkg::S_STEP;
        end else if (step_pop) begin
          state_nxt = (depth_r == DW'(1)) ? gmds_pkg::S_FETCH : gmds_pkg::S_POP;
        end
      end
      gmds_pkg::S_POP: begin
        state_nxt = gmds_pkg::S_FETCH;
      end
      gmds_pkg::S_FIN: begin
        if (res_take) state_nxt = gmds_pkg::S_LOAD;
      end
      default: state_nxt = gmds_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    fcnt_nxt      = fcnt_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    depth_nxt     = depth_r;
    moves_nxt     = moves_r;
    found_nxt     = found_r;
    ovf_nxt       = ovf_r;
    mark_nxt      = mark_r;
    rd_ok_nxt     = rd_ok_r;
    row_valid_nxt = row_valid_r;
    up_nxt        = up_r;
    mid_nxt       = mid_r;
    dn_nxt        = dn_r;
    g_we          = 1'b0;
    g_waddr       = ridx;
    g_wdata       = mid_r | cur_bit;
    g_re          = 1'b0;
    g_raddr       = ridx;
    s_we          = 1'b0;
    s_waddr       = depth_r[SAW-1:0];
    s_wdata       = {mv_row, mv_col};
    s_re          = 1'b0;
    s_raddr       = pop_top[SAW-1:0];
    ld_stall      = 1'b1;
    res_valid     = 1'b0;
    case (state_r)
      gmds_pkg::S_LOAD: begin
        ld_stall = 1'b0;
        if (ld.valid && row_in_grid) begin
          g_we    = 1'b1;
          g_waddr = ld.row_index[AW-1:0];
          g_wdata = {{SIDE{1'b0}}, ld.row_bits[SIDE-1:0]};
        end
      end
      gmds_pkg::S_INIT: begin
        depth_nxt   = '0;
        moves_nxt   = '0;
        found_nxt   = 1'b0;
        ovf_nxt     = 1'b0;
        mark_nxt    = 1'b1;
        fcnt_nxt    = '0;
        cur_row_nxt = cfg.start_row;
        cur_col_nxt = cfg.start_col;
      end
      gmds_pkg::S_FETCH: begin
        g_re     = 1'b1;
        fcnt_nxt = fcnt_r + 1'b1;
        case (fcnt_r)
          2'd0: begin
            g_raddr   = up_addr;
            rd_ok_nxt = !at_top && row_valid_r[up_addr];
          end
          2'd1: begin
            g_raddr   = ridx;
            rd_ok_nxt = row_valid_r[ridx];
            up_nxt    = fetched;
          end
          2'd2: begin
            g_raddr   = dn_addr;
            rd_ok_nxt = !at_bot && row_valid_r[dn_addr];
            mid_nxt   = fetched;
          end
          default: begin
            g_re   = 1'b0;
            dn_nxt = fetched;
          end
        endcase
      end
      gmds_pkg::S_STEP: begin
        if (step_mark) begin
          g_we     = 1'b1;
          mid_nxt  = mid_r | cur_bit;
          mark_nxt = 1'b0;
        end
        if (step_exit) found_nxt = 1'b1;
        if (step_ovf) ovf_nxt = 1'b1;
        if (step_push) begin
          s_we        = 1'b1;
          depth_nxt   = depth_r + 1'b1;
          moves_nxt   = moves_inc;
          cur_row_nxt = mv_row;
          cur_col_nxt = mv_col;
          fcnt_nxt    = '0;
          g_we        = 1'b1;
          if (mv_up) begin
            g_waddr = up_addr;
            g_wdata = up_r | cur_bit;
          end else if (mv_down) begin
            g_waddr = dn_addr;
            g_wdata = dn_r | cur_bit;
          end else begin
            g_wdata = mid_r | mv_bit;
            mid_nxt = mid_r | mv_bit;
          end
        end
        if (step_pop) begin
          depth_nxt = depth_r - 1'b1;
          moves_nxt = moves_inc;
          fcnt_nxt  = '0;
          if (depth_r == DW'(1)) begin
            cur_row_nxt = cfg.start_row;
            cur_col_nxt = cfg.start_col;
          end else begin
            s_re = 1'b1;
          end
        end
      end
      gmds_pkg::S_POP: begin
        cur_row_nxt = s_rdata[2*CW-1:CW];
        cur_col_nxt = s_rdata[CW-1:0];
      end
      gmds_pkg::S_FIN: begin
        res_valid = 1'b1;
        if (res_take) row_valid_nxt = '0;
      end
      default: begin
        ld_stall = 1'b1;
      end
    endcase
    if (g_we) row_valid_nxt[g_waddr] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gmds_pkg::S_LOAD;
      fcnt_r      <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      depth_r     <= '0;
      moves_r     <= '0;
      found_r     <= 1'b0;
      ovf_r       <= 1'b0;
      mark_r      <= 1'b0;
      rd_ok_r     <= 1'b0;
      row_valid_r <= '0;
    end else begin
      state_r     <= state_nxt;
      fcnt_r      <= fcnt_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      depth_r     <= depth_nxt;
      moves_r     <= moves_nxt;
      found_r     <= found_nxt;
      ovf_r       <= ovf_nxt;
      mark_r      <= mark_nxt;
      rd_ok_r     <= rd_ok_nxt;
      row_valid_r <= row_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    up_r  <= up_nxt;
    mid_r <= mid_nxt;
    dn_r  <= dn_nxt;
  end

  assign res.found          = found_r;
  assign res.path_length    = gmds_pkg::PATH_W'(depth_r);
  assign res.move_count     = moves_r;
  assign res.stack_overflow = ovf_r;

  `GMDS_ASSERT_NEVER(a_push_full, s_we && stack_full, "push into a full stack")
  `GMDS_ASSERT_NEVER(a_stack_clash, s_we && s_re, "stack read and write in one cycle")
  `GMDS_ASSERT_IMP(a_moves_step, !$stable(moves_r), moves_r == $past(moves_r) + 1'b1 || moves_r == '0, "move count jumped")
  `GMDS_ASSERT_NXT(a_vert_refetch, in_step && g_we && g_waddr != ridx, state_r == gmds_pkg::S_FETCH, "vertical move without refetch")

endmodule
`default_nettype wire

FILE: sv/grid_maze_dfs_solver_top.sv
// Depth-first maze solver. Rows of the maze are loaded one transfer per cycle;
// the transfer flagged last_row starts the walk, and the input stalls until its
// result has been moved into the output register. The grid state lives in one
// single-port-read memory (open and visited bits per row) cached as three row
// registers around the walker. A horizontal forward move stays in the step
// state; a vertical move goes through a refetch of the neighboring rows; a
// backtrack takes a step, a stack read when the stack stays non-empty, and
// the refetch. Walk setup and the refetch come before the first step, which
// marks the start cell; the result then waits for room in the output register.
// Per-row valid flags clear the grid and visited marks at once, so there is no
// clearing pass. The stack has STACK_DEPTH entries; a push into a full stack
// ends the walk with stack_overflow set.
`default_nettype none
module grid_maze_dfs_solver_top #(
  parameter int GRID_SIDE   = gmds_pkg::GRID_SIDE_DEF,
  parameter int STACK_DEPTH = gmds_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [gmds_pkg::CW-1:0]             in_row_index,
  input  wire logic [gmds_pkg::ROW_BITS_W-1:0]     in_row_bits,
  input  wire logic                                in_last_row,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_found,
  output logic      [gmds_pkg::PATH_W-1:0]         out_path_length,
  output logic      [gmds_pkg::MOVE_W-1:0]         out_move_count,
  output logic                                     out_stack_overflow,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [gmds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [gmds_pkg::CW-1:0]             cfg_data
);

  gmds_pkg::load_t   ld;
  gmds_pkg::cfg_t    cfg_r, cfg_nxt;
  gmds_pkg::result_t res, out_r;
  logic              res_valid, res_take;
  logic              out_valid_r, out_valid_nxt;

  assign ld.valid     = in_valid;
  assign ld.row_index = in_row_index;
  assign ld.row_bits  = in_row_bits;
  assign ld.last_row  = in_last_row;

  gmds_walker #(.GRID_SIDE(GRID_SIDE), .STACK_DEPTH(STACK_DEPTH)) u_walker (
    .clk(clk), .rst_n(rst_n),
    .ld(ld), .ld_stall(in_stall),
    .cfg(cfg_r),
    .res_valid(res_valid), .res(res), .res_take(res_take)
  );

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        gmds_pkg::CFG_START_ROW: cfg_nxt.start_row = cfg_data;
        gmds_pkg::CFG_START_COL: cfg_nxt.start_col = cfg_data;
        gmds_pkg::CFG_EXIT_ROW:  cfg_nxt.exit_row  = cfg_data;
        gmds_pkg::CFG_EXIT_COL:  cfg_nxt.exit_col  = cfg_data;
        default:                 cfg_nxt           = cfg_r;
      endcase
    end
  end

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_row <= gmds_pkg::RST_START_ROW;
      cfg_r.start_col <= gmds_pkg::RST_START_COL;
      cfg_r.exit_row  <= gmds_pkg::RST_EXIT_ROW;
      cfg_r.exit_col  <= gmds_pkg::RST_EXIT_COL;
      out_valid_r     <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_r <= res;
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_r.found;
  assign out_path_length    = out_r.path_length;
  assign out_move_count     = out_r.move_count;
  assign out_stack_overflow = out_r.stack_overflow;

endmodule
`default_nettype wire

FILE: verif/grid_maze_dfs_solver_top_tb.sv
`timescale 1ns / 1ps
module grid_maze_dfs_solver_top_tb;
  import gmds_pkg::*;

  localparam int SIDE            = GRID_SIDE_DEF;
  localparam int STACK_CAP       = STACK_DEPTH_DEF;
  localparam int IDLE_LIMIT      = 60000;
  localparam int PRESSURE_CYCLES = 400;
  localparam int ROW_TARGET      = 1550;
  localparam int CALM_ROWS       = 250;
  localparam int PHASE_ROWS      = 150;
  localparam int REPORT_MAX      = 10;

  typedef enum int {GO_RIGHT, GO_UP, GO_LEFT, GO_DOWN} heading_t;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [CW-1:0]         in_row_index = '0;
  logic [ROW_BITS_W-1:0] in_row_bits  = '0;
  logic                  in_last_row  = 1'b0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic                  out_found;
  logic [PATH_W-1:0]     out_path_length;
  logic [MOVE_W-1:0]     out_move_count;
  logic                  out_stack_overflow;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index    = CFG_START_ROW;
  logic [CW-1:0]         cfg_data     = '0;

  logic [ROW_BITS_W-1:0] grid_open [SIDE];
  cfg_t                  endpoints;
  result_t               pending_results [$];
  result_t               want;
  bit                    gaps_on      = 1'b1;
  int                    rows_sent    = 0;
  int                    mismatch_cnt = 0;
  int                    idle_cycles  = 0;
  int                    hold_req     = 0;
  int                    hold_done    = 0;
  int                    hold_left    = 0;
  int                    stall_left   = 0;

  grid_maze_dfs_solver_top dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_stall,
    .in_row_index,
    .in_row_bits,
    .in_last_row,
    .out_valid,
    .out_stall,
    .out_found,
    .out_path_length,
    .out_move_count,
    .out_stack_overflow,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  always #1 clk = ~clk;

  function automatic result_t solve_maze();
    logic [ROW_BITS_W-1:0] seen [SIDE];
    logic [CW-1:0]         trail_row [STACK_CAP];
    logic [CW-1:0]         trail_col [STACK_CAP];
    int                    depth;
    int                    moves;
    int                    r;
    int                    c;
    int                    nr;
    int                    nc;
    int                    dir;
    bit                    open_nb;
    result_t               res;
    res   = '0;
    depth = 0;
    moves = 0;
    nr    = 0;
    nc    = 0;
    r     = endpoints.start_row;
    c     = endpoints.start_col;
    foreach (seen[i]) seen[i] = '0;
    seen[r][c] = 1'b1;
    forever begin
      if (r == endpoints.exit_row && c == endpoints.exit_col) begin
        res.found = 1'b1;
        break;
      end
      open_nb = 1'b0;
      for (dir = GO_RIGHT; dir <= GO_DOWN && !open_nb; dir++) begin
        nr = r;
        nc = c;
        case (dir)
          GO_RIGHT: nc = c + 1;
          GO_UP:    nr = r - 1;
          GO_LEFT:  nc = c - 1;
          default:  nr = r + 1;
        endcase
        if (nr >= 0 && nr < SIDE && nc >= 0 && nc < SIDE)
          open_nb = grid_open[nr][nc] && !seen[nr][nc];
      end
      if (open_nb) begin
        if (depth >= STACK_CAP) begin
          res.stack_overflow = 1'b1;
          break;
        end
        r = nr;
        c = nc;
        seen[r][c] = 1'b1;
        trail_row[depth] = CW'(r);
        trail_col[depth] = CW'(c);
        depth++;
        if (moves < MOVE_MAX) moves++;
      end else begin
        if (depth == 0) break;
        depth--;
        if (moves < MOVE_MAX) moves++;
        if (depth == 0) begin
          r = endpoints.start_row;
          c = endpoints.start_col;
        end else begin
          r = trail_row[depth-1];
          c = trail_col[depth-1];
        end
      end
    end
    res.path_length = PATH_W'(depth);
    res.move_count  = MOVE_W'(moves);
    foreach (grid_open[i]) grid_open[i] = '0;
    return res;
  endfunction

  function automatic logic [ROW_BITS_W-1:0] random_row(input int density);
    logic [ROW_BITS_W-1:0] bits;
    bits = $urandom();
    case (density)
      0:       bits = bits & $urandom();
      1:       ;
      2:       bits = bits | $urandom();
      default: bits = bits | $urandom() | $urandom();
    endcase
    return bits;
  endfunction

  task automatic load_row(input logic [CW-1:0] idx, input logic [ROW_BITS_W-1:0] bits,
                          input logic last);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_row_index <= idx;
    in_row_bits  <= bits;
    in_last_row  <= last;
    do @(posedge clk); while (in_stall);
    rows_sent++;
    grid_open[idx] = bits;
    if (last) pending_results.push_back(solve_maze());
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_START_ROW: endpoints.start_row = val;
      CFG_START_COL: endpoints.start_col = val;
      CFG_EXIT_ROW:  endpoints.exit_row  = val;
      default:       endpoints.exit_col  = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic place_endpoints(input logic [CW-1:0] sr, sc, er, ec);
    write_reg(CFG_START_ROW, sr);
    write_reg(CFG_START_COL, sc);
    write_reg(CFG_EXIT_ROW, er);
    write_reg(CFG_EXIT_COL, ec);
  endtask

  task automatic test_reset_defaults();
    load_row(CW'(0), '0, 1'b1);
    load_row(CW'(1), '1, 1'b1);
    drain_results();
  endtask

  task automatic test_start_is_exit();
    place_endpoints(CW'(5), CW'(7), CW'(5), CW'(7));
    load_row(CW'(5), '0, 1'b1);
    drain_results();
  endtask

  task automatic test_grid_edges();
    place_endpoints(CW'(0), CW'(0), CW'(0), CW'(31));
    load_row(CW'(0), '1, 1'b1);
    drain_results();
    place_endpoints(CW'(31), CW'(31), CW'(31), CW'(0));
    load_row(CW'(31), '1, 1'b1);
    drain_results();
  endtask

  task automatic test_backtracking();
    place_endpoints(CW'(0), CW'(0), CW'(2), CW'(5));
    load_row(CW'(0), 32'h0000_001F, 1'b0);
    load_row(CW'(1), 32'h0000_0001, 1'b0);
    load_row(CW'(2), 32'h0000_003F, 1'b1);
    load_row(CW'(0), 32'h0000_001F, 1'b0);
    load_row(CW'(1), 32'h0000_0001, 1'b0);
    load_row(CW'(2), 32'h0000_003E, 1'b1);
    drain_results();
  endtask

  task automatic test_row_reload();
    place_endpoints(CW'(4), CW'(0), CW'(4), CW'(9));
    load_row(CW'(4), 32'h0000_03FF, 1'b0);
    load_row(CW'(4), 32'h0000_000F, 1'b0);
    load_row(CW'(9), 32'hFFFF_FFFF, 1'b1);
    drain_results();
  endtask

  task automatic test_stack_overflow();
    int k;
    place_endpoints(CW'(0), CW'(0), CW'(31), CW'(31));
    for (k = 0; k < 16; k++) load_row(CW'(k), '1, 1'b0);
    load_row(CW'(16), 32'h0000_0003, 1'b1);
    drain_results();
  endtask

  task automatic test_output_pressure();
    int k;
    place_endpoints(CW'(3), CW'(3), CW'(3), CW'(9));
    hold_req++;
    for (k = 0; k < 40; k++) load_row(CW'(3), random_row(2), 1'b1);
    drain_results();
  endtask

  task automatic send_random_maze();
    int            n;
    int            k;
    int            density;
    bit            full;
    logic [CW-1:0] idx;
    full    = ($urandom_range(0, 4) == 0);
    n       = full ? SIDE : $urandom_range(1, 6);
    density = $urandom_range(0, 3);
    for (k = 0; k < n; k++) begin
      if (full) idx = CW'(k);
      else if ($urandom_range(0, 1) == 0)
        idx = CW'(endpoints.start_row + $urandom_range(0, 6) - 3);
      else idx = CW'($urandom_range(0, SIDE - 1));
      load_row(idx, random_row(density), k == n - 1);
    end
  endtask

  task automatic test_random_mazes(input int row_goal);
    int            phase_end;
    logic [CW-1:0] sr;
    logic [CW-1:0] sc;
    logic [CW-1:0] er;
    logic [CW-1:0] ec;
    while (rows_sent < row_goal) begin
      sr = CW'($urandom());
      sc = CW'($urandom());
      case ($urandom_range(0, 3))
        0: begin
          sr = $urandom_range(0, 1) ? CW'(SIDE - 1) : CW'(0);
          sc = $urandom_range(0, 1) ? CW'(SIDE - 1) : CW'(0);
          er = ~sr;
          ec = ~sc;
        end
        1: begin
          er = CW'($urandom());
          ec = CW'($urandom());
        end
        default: begin
          er = CW'(sr + $urandom_range(0, 8) - 4);
          ec = CW'(sc + $urandom_range(0, 8) - 4);
        end
      endcase
      place_endpoints(sr, sc, er, ec);
      phase_end = rows_sent + PHASE_ROWS;
      while (rows_sent < phase_end && rows_sent < row_goal) send_random_maze();
      drain_results();
    end
  endtask

  always @(negedge clk) begin
    if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_left <= PRESSURE_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
          $display("unexpected transfer: found=%0b path=%0d moves=%0d ovf=%0b",
                   out_found, out_path_length, out_move_count, out_stack_overflow);
      end else begin
        want = pending_results.pop_front();
        if (out_found !== want.found || out_path_length !== want.path_length ||
            out_move_count !== want.move_count ||
            out_stack_overflow !== want.stack_overflow) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX)
            $display("mismatch: expected found=%0b path=%0d moves=%0d ovf=%0b, got found=%0b path=%0d moves=%0d ovf=%0b",
                     want.found, want.path_length, want.move_count, want.stack_overflow,
                     out_found, out_path_length, out_move_count, out_stack_overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    endpoints = '{start_row: RST_START_ROW, start_col: RST_START_COL,
                  exit_row: RST_EXIT_ROW, exit_col: RST_EXIT_COL};
    foreach (grid_open[i]) grid_open[i] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_start_is_exit();
    test_grid_edges();
    test_backtracking();
    test_row_reload();
    test_stack_overflow();
    test_output_pressure();
    test_random_mazes(ROW_TARGET - CALM_ROWS);
    gaps_on = 1'b0;
    test_random_mazes(ROW_TARGET);
    repeat (50) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/gmds_pkg.sv
sv/gmds_ram.sv
sv/gmds_walker.sv
sv/grid_maze_dfs_solver_top.sv
verif/grid_maze_dfs_solver_top_tb.sv
